[hw/rtl/rsdz_pkg.sv]
// Shared constants and types for the radial stick dead zone unit.
`default_nettype none
package rsdz_pkg;
   localparam int SampleBits = 16;
   localparam int MagBits    = SampleBits;
   localparam int SqBits     = 2 * MagBits + 1;
   localparam int LenBits    = MagBits + 1;
   localparam int CfgBits    = 16;
   localparam int FracBits   = 15;
   localparam int OutBits    = 16;
   localparam int IdxBits    = 1;
   localparam int NumBits    = FracBits + LenBits;
   localparam int DivQBits   = FracBits + 1;
   localparam int RootSteps  = LenBits;
   localparam int DivSteps   = DivQBits;

   localparam logic [FracBits-1:0] OneQ15 = {FracBits{1'b1}};

   localparam logic [IdxBits-1:0] RegDeadZone  = 1'b0;
   localparam logic [IdxBits-1:0] RegFullScale = 1'b1;

   typedef struct packed {
      logic                negx;
      logic                negy;
      logic [MagBits-1:0]  ax;
      logic [MagBits-1:0]  ay;
      logic                centered;
      logic                sat;
      logic [CfgBits-1:0]  dz;
      logic [CfgBits:0]    span;
   } ctl_type;
endpackage
`default_nettype wire

[hw/rtl/rsdz_root_cell.sv]
// One restoring square root cell: decides one result bit per cycle while advance is high and passes on.
`default_nettype none
module rsdz_root_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [4:0]                     step,
   input  wire logic                           in_valid,
   input  wire logic [rsdz_pkg::SqBits-1:0]    in_rem,
   input  wire logic [rsdz_pkg::LenBits-1:0]   in_root,
   input  wire rsdz_pkg::ctl_type              in_ctl,
   output logic                                out_valid,
   output logic [rsdz_pkg::SqBits-1:0]         out_rem,
   output logic [rsdz_pkg::LenBits-1:0]        out_root,
   output rsdz_pkg::ctl_type                   out_ctl
);
   // root bit b = LenBits-1-step; trial = (2*root*2^b + 2^(2b))
   logic [rsdz_pkg::SqBits+1:0] trial;
   logic [5:0]                  bpos;
   logic                        take;
   logic                        valid_ff;
   logic [rsdz_pkg::SqBits-1:0] rem_ff,  rem_in;
   logic [rsdz_pkg::LenBits-1:0] root_ff, root_in;
   rsdz_pkg::ctl_type           ctl_ff;

   always_comb begin
      bpos  = 6'(rsdz_pkg::LenBits - 1) - 6'(step);
      trial = ((rsdz_pkg::SqBits+2)'(in_root) << (bpos + 6'd1))
            | ((rsdz_pkg::SqBits+2)'(1) << (bpos << 1));
      take  = (rsdz_pkg::SqBits+2)'(in_rem) >= trial;
      rem_in  = take ? in_rem - rsdz_pkg::SqBits'(trial) : in_rem;
      root_in = take ? in_root | (rsdz_pkg::LenBits'(1) << bpos) : in_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_ctl   = ctl_ff;
endmodule
`default_nettype wire

[hw/rtl/rsdz_div_cell.sv]
// One restoring divider cell: one quotient bit per cycle while advance is high, three lanes side by side.
`default_nettype none
module rsdz_div_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic [4:0]                      step,
   input  wire logic                            in_valid,
   input  wire logic [3*rsdz_pkg::NumBits-1:0]  in_num,
   input  wire logic [3*rsdz_pkg::NumBits-1:0]  in_den,
   input  wire logic [3*rsdz_pkg::DivQBits-1:0] in_quo,
   input  wire rsdz_pkg::ctl_type               in_ctl,
   output logic                                 out_valid,
   output logic [3*rsdz_pkg::NumBits-1:0]       out_num,
   output logic [3*rsdz_pkg::NumBits-1:0]       out_den,
   output logic [3*rsdz_pkg::DivQBits-1:0]      out_quo,
   output rsdz_pkg::ctl_type                    out_ctl
);
   localparam int NB = rsdz_pkg::NumBits;
   localparam int QB = rsdz_pkg::DivQBits;
   logic [4:0]           bpos;
   logic [3*NB-1:0]      num_in;
   logic [3*QB-1:0]      quo_in;
   logic [NB+QB-1:0]     sh;
   logic                 valid_ff;
   logic [3*NB-1:0]      num_ff, den_ff;
   logic [3*QB-1:0]      quo_ff;
   rsdz_pkg::ctl_type    ctl_ff;

   always_comb begin
      bpos = 5'(QB - 1) - step;
      num_in = in_num;
      quo_in = in_quo;
      sh = '0;
      for (int l = 0; l < 3; l++) begin
         sh = (NB+QB)'(in_den[l*NB +: NB]) << bpos;
         if ((NB+QB)'(in_num[l*NB +: NB]) >= sh) begin
            num_in[l*NB +: NB] = in_num[l*NB +: NB] - NB'(sh);
            quo_in[l*QB + int'(bpos)] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         num_ff <= num_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_ctl   = ctl_ff;
endmodule
`default_nettype wire

[hw/rtl/radial_stick_dead_zone_unit.sv]
// Top level: square, root cell chain, fraction divide chain, axis divide chain.
// Pipeline: 2 + 17 + 16 + 1 + 16 + 1 = 53 register stages.
// Throughput, unless frozen: one transfer per cycle; each cell row advances one stage per cycle.
// The whole pipe freezes when the output register holds an untaken result.
// Reset clears all valid bits and loads dead_zone 8000, full_scale 30000.
`default_nettype none
module radial_stick_dead_zone_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // raw_x[15:0], raw_y[31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out_x[15:0], out_y[31:16]
   output logic             rsp_tuser,   // centered
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int SB = rsdz_pkg::SampleBits;
   localparam int MB = rsdz_pkg::MagBits;
   localparam int SQ = rsdz_pkg::SqBits;
   localparam int LB = rsdz_pkg::LenBits;
   localparam int NB = rsdz_pkg::NumBits;
   localparam int QB = rsdz_pkg::DivQBits;
   localparam int CB = rsdz_pkg::CfgBits;
   localparam int FB = rsdz_pkg::FracBits;
   localparam int OB = rsdz_pkg::OutBits;
   localparam int RS = rsdz_pkg::RootSteps;
   localparam int DS = rsdz_pkg::DivSteps;

   logic [CB-1:0] dz_ff, fs_ff;
   logic          adv;
   logic          out_valid_ff;
   logic [OB-1:0] ox_ff, oy_ff;
   logic          cen_ff;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= CB'(8000);
         fs_ff <= CB'(30000);
      end else if (csr_we) begin
         if (csr_index == rsdz_pkg::RegDeadZone) dz_ff <= csr_wdata;
         if (csr_index == rsdz_pkg::RegFullScale) fs_ff <= csr_wdata;
      end
   end

   // stage A: magnitudes and signs
   logic              a_v_ff;
   logic [MB-1:0]     a_ax_ff, a_ay_ff;
   logic              a_nx_ff, a_ny_ff;
   logic [SB-1:0]     rx, ry;
   assign rx = req_tdata[SB-1:0];
   assign ry = req_tdata[2*SB-1:SB];

   // stage B: squares, dead zone test
   logic              b_v_ff;
   logic [SQ-1:0]     b_sq_ff;
   rsdz_pkg::ctl_type b_ctl_ff;
   logic [2*CB-1:0]   dz2;
   logic [SQ-1:0]     sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
      end
      if (adv) begin
         a_nx_ff <= rx[SB-1];
         a_ny_ff <= ry[SB-1];
         a_ax_ff <= rx[SB-1] ? MB'(-rx) : MB'(rx);
         a_ay_ff <= ry[SB-1] ? MB'(-ry) : MB'(ry);
      end
   end

   always_comb begin
      sq_in = SQ'(a_ax_ff) * SQ'(a_ax_ff) + SQ'(a_ay_ff) * SQ'(a_ay_ff);
      dz2   = (2*CB)'(dz_ff) * (2*CB)'(dz_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_sq_ff           <= sq_in;
         b_ctl_ff.negx     <= a_nx_ff;
         b_ctl_ff.negy     <= a_ny_ff;
         b_ctl_ff.ax       <= a_ax_ff;
         b_ctl_ff.ay       <= a_ay_ff;
         b_ctl_ff.centered <= (SQ+1)'(sq_in) < (SQ+1)'(dz2);
         b_ctl_ff.sat      <= fs_ff <= dz_ff;
         b_ctl_ff.dz       <= dz_ff;
         b_ctl_ff.span     <= (CB+1)'(fs_ff) - (CB+1)'(dz_ff);
      end
   end

   // root chain
   logic [RS:0]       r_v;
   logic [SQ-1:0]     r_rem [RS+1];
   logic [LB-1:0]     r_root [RS+1];
   rsdz_pkg::ctl_type r_ctl [RS+1];
   assign r_v[0]    = b_v_ff;
   assign r_rem[0]  = b_sq_ff;
   assign r_root[0] = '0;
   assign r_ctl[0]  = b_ctl_ff;

   for (genvar i = 0; i < RS; i++) begin : g_root
      logic              v_o;
      logic [SQ-1:0]     rem_o;
      logic [LB-1:0]     root_o;
      rsdz_pkg::ctl_type ctl_o;
      rsdz_root_cell u_cell (
         .clock(clock), .reset(reset), .advance(adv), .step(5'(i)),
         .in_valid(r_v[i]), .in_rem(r_rem[i]), .in_root(r_root[i]),
         .in_ctl(r_ctl[i]),
         .out_valid(v_o), .out_rem(rem_o), .out_root(root_o), .out_ctl(ctl_o)
      );
      assign r_v[i+1]    = v_o;
      assign r_rem[i+1]  = rem_o;
      assign r_root[i+1] = root_o;
      assign r_ctl[i+1]  = ctl_o;
   end

   // Fraction divide chain: lane 0 = 32767*(L-dz)/span.
   logic [LB-1:0]     len;
   logic [NB-1:0]     fnum;
   assign len  = r_root[RS];
   assign fnum = NB'(rsdz_pkg::OneQ15) * NB'(len - LB'(r_ctl[RS].dz));

   logic [DS:0]       f_v;
   logic [3*NB-1:0]   f_num [DS+1];
   logic [3*NB-1:0]   f_den [DS+1];
   logic [3*QB-1:0]   f_quo [DS+1];
   rsdz_pkg::ctl_type f_ctl [DS+1];
   logic [LB-1:0]     f_len [DS+1];
   logic              fnum_ok;
   assign fnum_ok  = len >= LB'(r_ctl[RS].dz);
   assign f_v[0]   = r_v[RS];
   assign f_num[0] = {(2*NB)'(0), fnum_ok ? fnum : NB'(0)};
   assign f_den[0] = {(2*NB)'(0), NB'(r_ctl[RS].span)};
   assign f_quo[0] = '0;
   assign f_ctl[0] = r_ctl[RS];
   assign f_len[0] = len;

   for (genvar i = 0; i < DS; i++) begin : g_frac
      logic [LB-1:0] len_ff;
      rsdz_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(adv), .step(5'(i)),
         .in_valid(f_v[i]), .in_num(f_num[i]), .in_den(f_den[i]),
         .in_quo(f_quo[i]), .in_ctl(f_ctl[i]),
         .out_valid(f_v[i+1]), .out_num(f_num[i+1]), .out_den(f_den[i+1]),
         .out_quo(f_quo[i+1]), .out_ctl(f_ctl[i+1])
      );
      always_ff @(posedge clock) begin
         if (adv) len_ff <= f_len[i];
      end
      assign f_len[i+1] = len_ff;
   end

   // stage M: clamp fraction, form axis products
   logic              m_v_ff;
   logic [NB-1:0]     m_px_ff, m_py_ff;
   logic [LB-1:0]     m_len_ff;
   rsdz_pkg::ctl_type m_ctl_ff;
   logic [QB-1:0]     fq;
   logic [FB-1:0]     frac;
   assign fq   = f_quo[DS][QB-1:0];
   assign frac = (f_ctl[DS].sat || fq > QB'(rsdz_pkg::OneQ15))
               ? rsdz_pkg::OneQ15 : FB'(fq);

   always_ff @(posedge clock) begin
      if (reset)    m_v_ff <= 1'b0;
      else if (adv) m_v_ff <= f_v[DS];
      if (adv) begin
         m_px_ff  <= NB'(f_ctl[DS].ax) * NB'(frac);
         m_py_ff  <= NB'(f_ctl[DS].ay) * NB'(frac);
         m_len_ff <= f_len[DS];
         m_ctl_ff <= f_ctl[DS];
      end
   end

   logic [DS:0]       d_v;
   logic [3*NB-1:0]   d_num [DS+1];
   logic [3*NB-1:0]   d_den [DS+1];
   logic [3*QB-1:0]   d_quo [DS+1];
   rsdz_pkg::ctl_type d_ctl [DS+1];
   assign d_v[0]   = m_v_ff;
   assign d_num[0] = {NB'(0), m_py_ff, m_px_ff};
   assign d_den[0] = {NB'(1), NB'(m_len_ff), NB'(m_len_ff)};
   assign d_quo[0] = '0;
   assign d_ctl[0] = m_ctl_ff;

   for (genvar i = 0; i < DS; i++) begin : g_axis
      rsdz_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(adv), .step(5'(i)),
         .in_valid(d_v[i]), .in_num(d_num[i]), .in_den(d_den[i]),
         .in_quo(d_quo[i]), .in_ctl(d_ctl[i]),
         .out_valid(d_v[i+1]), .out_num(d_num[i+1]), .out_den(d_den[i+1]),
         .out_quo(d_quo[i+1]), .out_ctl(d_ctl[i+1])
      );
   end

   // final result formatting
   logic [OB-1:0] mx, my, fx, fy;
   logic          zlen;
   rsdz_pkg::ctl_type ec;
   assign ec   = d_ctl[DS];
   assign zlen = d_den[DS][NB-1:0] == NB'(0);
   assign mx   = (zlen || ec.centered) ? OB'(0) : OB'(d_quo[DS][QB-1:0]);
   assign my   = (zlen || ec.centered) ? OB'(0) : OB'(d_quo[DS][2*QB-1:QB]);
   assign fx   = ec.negx ? OB'(-mx) : mx;
   assign fy   = ec.negy ? OB'(-my) : my;

   // output register
   always_ff @(posedge clock) begin
      if (reset)    out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= d_v[DS];
      if (adv) begin
         ox_ff  <= fx;
         oy_ff  <= fy;
         cen_ff <= ec.centered;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {oy_ff, ox_ff};
   assign rsp_tuser  = cen_ff;
endmodule
`default_nettype wire

[tb/radial_stick_dead_zone_checker.sv]
// Checker for the radial stick dead zone unit: predicts each response and compares it.
`default_nettype none
module radial_stick_dead_zone_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               pending
);
   typedef struct packed {
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic        centered;
   } stick_out_type;

   logic [15:0]   dz_reg, fs_reg;
   stick_out_type expected_q[$];

   function automatic logic [16:0] root_floor(input logic [32:0] s);
      logic [16:0] r;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         if ((({16'd0, r} | (33'd1 << b)) * ({16'd0, r} | (33'd1 << b))) <= {33'd0, s})
            r[b] = 1'b1;
      end
      return r;
   endfunction

   function automatic stick_out_type condition(input logic [15:0] rx,
                                               input logic [15:0] ry);
      stick_out_type o;
      logic [15:0] ax, ay;
      logic [63:0] sq, len, frac, mx, my;
      ax = rx[15] ? 16'(-rx) : rx;
      ay = ry[15] ? 16'(-ry) : ry;
      sq = 64'(ax) * ax + 64'(ay) * ay;
      o = '0;
      if (sq < 64'(dz_reg) * dz_reg) begin
         o.centered = 1'b1;
         return o;
      end
      len = 64'(root_floor(33'(sq)));
      if (fs_reg <= dz_reg) frac = 32767;
      else begin
         frac = (64'd32767 * (len - dz_reg)) / (fs_reg - dz_reg);
         if (frac > 32767) frac = 32767;
      end
      if (len == 0) begin
         mx = 0;
         my = 0;
      end else begin
         mx = (64'(ax) * frac) / len;
         my = (64'(ay) * frac) / len;
      end
      o.out_x = rx[15] ? 16'(-mx) : 16'(mx);
      o.out_y = ry[15] ? 16'(-my) : 16'(my);
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      stick_out_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         dz_reg <= 16'd8000;
         fs_reg <= 16'd30000;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("response transfer with nothing expected");
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[15:0] !== want.out_x) begin
                  $error("out_x expected %0d got %0d", $signed(want.out_x),
                         $signed(rsp_tdata[15:0]));
                  errs++;
               end
               if (rsp_tdata[31:16] !== want.out_y) begin
                  $error("out_y expected %0d got %0d", $signed(want.out_y),
                         $signed(rsp_tdata[31:16]));
                  errs++;
               end
               if (rsp_tuser !== want.centered) begin
                  $error("centered expected %0b got %0b", want.centered, rsp_tuser);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         if (req_tvalid && req_tready)
            expected_q.push_back(condition(req_tdata[15:0], req_tdata[31:16]));
         if (csr_we) begin
            if (csr_index == rsdz_pkg::RegDeadZone) dz_reg <= csr_wdata;
            else if (csr_index == rsdz_pkg::RegFullScale) fs_reg <= csr_wdata;
         end
      end
   end
endmodule
`default_nettype wire

[tb/radial_stick_dead_zone_unit_tb.sv]
// Testbench top: stimulus, configuration phases, back pressure and verdict.
`default_nettype none
module radial_stick_dead_zone_unit_tb;
   localparam int DrainCycles = 80;
   localparam int IdleLimit   = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // raw_x[15:0], raw_y[31:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // out_x[15:0], out_y[31:16]
   logic        rsp_tuser;         // centered
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count, pending;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;

   logic [15:0] dz_set [6] = '{16'd8000, 16'd0, 16'd46341, 16'd20000, 16'd1, 16'd12000};
   logic [15:0] fs_set [6] = '{16'd30000, 16'd1, 16'd46341, 16'd10000, 16'd65535,
                               16'd12001};
   logic [15:0] dir [10] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                            16'h8001, 16'd8000, 16'd7999, 16'd30000, 16'hAAAA};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   radial_stick_dead_zone_unit u_top (.*);

   radial_stick_dead_zone_checker u_chk (.*);

   // receiver: random stall bursts, with a long hold-off on request
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < 300; i++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(3) == 0) begin
            n = $urandom_range(13, 1);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_sample(input logic [15:0] rx, input logic [15:0] ry);
      int gap;
      if (!calm && $urandom_range(4) == 0) begin
         gap = $urandom_range(13, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ry, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_axis(input logic [15:0] dz);
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(2 * dz + 16) - dz - 8);
         3: return 16'($urandom_range(32) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners at reset settings
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 5; j++)
            send_sample(dir[i * 2], dir[j * 2 + 1]);
      send_sample(16'd7999, 16'd0);
      send_sample(16'd8000, 16'd0);
      // sender keeps offering while the receiver holds off
      hold_rsp = 1'b1;
      for (int i = 0; i < 150; i++) send_sample(16'($urandom), 16'($urandom));
      for (int p = 0; p < 6; p++) begin
         quiesce();
         write_reg(rsdz_pkg::RegDeadZone, dz_set[p]);
         write_reg(rsdz_pkg::RegFullScale, fs_set[p]);
         csr_we <= 1'b0;
         if (p == 5) calm = 1'b1;
         send_sample(16'h0000, 16'h0000);
         send_sample(16'h8000, 16'h8000);
         send_sample(16'h7FFF, 16'h8000);
         for (int i = 0; i < 200; i++)
            send_sample(rand_axis(dz_set[p]), rand_axis(dz_set[p]));
      end
      quiesce();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
